// ===== sv/plob_pkg.sv =====
`timescale 1ns / 1ps
// Package for the price-level order book: kinds, status codes, state encoding.
// Depends on nothing; used by price_level_order_book_top.
package plob_pkg;

  localparam int MaxPriceDefault = 100;
  localparam int MaxDepthDefault = 64;
  localparam int QtyWidthDefault = 31;

  localparam logic [2:0] KIND_ADD    = 3'd0;
  localparam logic [2:0] KIND_MODIFY = 3'd1;
  localparam logic [2:0] KIND_CANCEL = 3'd2;
  localparam logic [2:0] KIND_TRADE  = 3'd3;
  localparam logic [2:0] KIND_DEPTH  = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD     = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;
  localparam logic [1:0] ST_EXCEEDS = 2'd3;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_UPD_RD,
    S_UPD_WR,
    S_DEPTH,
    S_OUT
  } state_e;

endpackage

// ===== sv/plob_mem.sv =====
`timescale 1ns / 1ps
// One side's level store: a single-port synchronous memory with registered read.
// Depends on nothing.
module plob_mem #(
  parameter int AddrWidth = 7,
  parameter int Depth     = 101,
  parameter int QtyWidth  = 31
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrWidth-1:0] addr_i,
  input  logic [QtyWidth-1:0]  wdata_i,
  output logic [QtyWidth-1:0]  rdata_o
);

  logic [QtyWidth-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ===== sv/plob_top_track.sv =====
`timescale 1ns / 1ps
// Per-level presence bits and best price search for both sides of the book.
// Depends on nothing.
module plob_top_track #(
  parameter int MaxPrice  = 100,
  parameter int AddrWidth = 7
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 set_i,
  input  logic                 side_i,
  input  logic [AddrWidth-1:0] addr_i,
  input  logic                 present_i,
  output logic [MaxPrice:0]    bid_map_o,
  output logic [MaxPrice:0]    ask_map_o,
  output logic                 bid_valid_o,
  output logic [AddrWidth-1:0] bid_o,
  output logic                 ask_valid_o,
  output logic [AddrWidth-1:0] ask_o
);

  logic [MaxPrice:0] bid_q, ask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bid_q <= '0;
      ask_q <= '0;
    end else if (set_i) begin
      if (side_i) begin
        ask_q[addr_i] <= present_i;
      end else begin
        bid_q[addr_i] <= present_i;
      end
    end
  end

  always_comb begin
    bid_o = '0;
    ask_o = '0;
    for (int i = 0; i <= MaxPrice; i++) begin
      if (bid_q[i]) begin
        bid_o = AddrWidth'(i);
      end
    end
    for (int i = MaxPrice; i >= 0; i--) begin
      if (ask_q[i]) begin
        ask_o = AddrWidth'(i);
      end
    end
  end

  assign bid_valid_o = |bid_q;
  assign ask_valid_o = |ask_q;
  assign bid_map_o   = bid_q;
  assign ask_map_o   = ask_q;

endmodule

// ===== sv/price_level_order_book_top.sv =====
`timescale 1ns / 1ps
// Price-level order book, top level: control sequencer, level stores and outputs.
// Depends on plob_pkg, plob_mem and plob_top_track.
//
// Each side's quantities live in a synchronous single-port memory of MaxPrice+1
// entries. After reset a clearing pass writes zero to every entry, and no item
// is accepted until it ends. An update passes through the accept state, which
// starts the read, the modify-and-write state, one spare state and the output
// state. A depth query passes through its accept state, then the walk state,
// which tests the price levels one after another from the best end, and the output
// state once for each level found; each level found is a result transfer.
// A depth query that finds nothing and an unknown kind go from the accept state
// straight to the output state. The output state holds while the output stalls.
module price_level_order_book_top
  import plob_pkg::*;
#(
  parameter int MaxPrice = plob_pkg::MaxPriceDefault,
  parameter int MaxDepth = plob_pkg::MaxDepthDefault,
  parameter int QtyWidth = plob_pkg::QtyWidthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          kind_i,
  input  logic                side_i,
  input  logic [6:0]          price_i,
  input  logic [QtyWidth-1:0] quantity_i,
  input  logic [6:0]          depth_count_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          status_o,
  output logic                best_bid_valid_o,
  output logic [6:0]          best_bid_o,
  output logic                best_ask_valid_o,
  output logic [6:0]          best_ask_o,
  output logic signed [7:0]   spread_o,
  output logic [7:0]          midpoint_twice_o,
  output logic                level_valid_o,
  output logic [6:0]          level_price_o,
  output logic [QtyWidth-1:0] level_quantity_o,
  output logic                last_o
);

  localparam int AW = $clog2(MaxPrice + 1);
  localparam int CW = $clog2(MaxDepth + 1);
  localparam logic [AW-1:0] MaxP = AW'(MaxPrice);
  localparam logic [QtyWidth-1:0] QtyMax = '1;

  state_e state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [2:0] kind_q, kind_d;
  logic side_q, side_d;
  logic [6:0] price_q, price_d;
  logic [QtyWidth-1:0] qty_q, qty_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] scan_q, scan_d;
  logic [AW-1:0] rd_q, rd_d;
  logic rd_last_q, rd_last_d;
  logic any_q, any_d;
  logic [1:0] st_q, st_d;
  logic [6:0] lp_q, lp_d;
  logic [QtyWidth-1:0] lq_q, lq_d;
  logic lv_q, lv_d, lastf_q, lastf_d;

  logic we_b, we_a, mem_side;
  logic [AW-1:0] maddr;
  logic [QtyWidth-1:0] wdata, rdata_b, rdata_a, rdata;
  logic trk_set, trk_present;
  logic [MaxPrice:0] bid_map, ask_map;
  logic bv, av;
  logic [AW-1:0] bb, ba;
  logic [QtyWidth:0] sum;
  logic bad_price;

  assign bad_price = ({25'd0, price_q} > 32'(MaxPrice));
  assign rdata = side_q ? rdata_a : rdata_b;
  assign sum = {1'b0, rdata} + {1'b0, qty_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;  side_q <= side_d;  price_q <= price_d;  qty_q <= qty_d;
    cnt_q <= cnt_d;  scan_q <= scan_d;  rd_q <= rd_d;  rd_last_q <= rd_last_d;
    any_q <= any_d;  st_q <= st_d;  lp_q <= lp_d;  lq_q <= lq_d;
    lv_q <= lv_d;  lastf_q <= lastf_d;
  end

  always_comb begin
    logic [CW-1:0] req;
    logic present;
    logic more;
    state_d = state_q;  clr_d = clr_q;
    kind_d = kind_q;  side_d = side_q;  price_d = price_q;  qty_d = qty_q;
    cnt_d = cnt_q;  scan_d = scan_q;  rd_d = rd_q;  rd_last_d = rd_last_q;
    any_d = any_q;  st_d = st_q;  lp_d = lp_q;  lq_d = lq_q;
    lv_d = lv_q;  lastf_d = lastf_q;
    in_stall_o = 1'b1;
    out_valid_o = 1'b0;
    we_b = 1'b0;  we_a = 1'b0;  mem_side = side_q;
    maddr = price_q[AW-1:0];
    wdata = '0;
    trk_set = 1'b0;  trk_present = 1'b0;
    req = '0;
    present = 1'b0;
    more = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        maddr = clr_q;
        we_b = 1'b1;  we_a = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == MaxP) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          kind_d = kind_i;  side_d = side_i;  price_d = price_i;  qty_d = quantity_i;
          st_d = ST_OK;  lv_d = 1'b0;  lp_d = '0;  lq_d = '0;  lastf_d = 1'b1;
          any_d = 1'b0;
          if (kind_i == KIND_DEPTH) begin
            req = (depth_count_i > 7'(MaxDepth)) ? CW'(MaxDepth) : CW'(depth_count_i);
            cnt_d = req;
            maddr = side_i ? '0 : MaxP;
            rd_d = maddr;
            rd_last_d = 1'b0;
            scan_d = side_i ? AW'(1) : MaxP - 1'b1;
            state_d = (req == '0 || (side_i ? ~|ask_map : ~|bid_map)) ? S_OUT : S_DEPTH;
          end else if (kind_i <= KIND_TRADE) begin
            maddr = price_i[AW-1:0];
            state_d = S_UPD_RD;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_UPD_RD: begin
        state_d = S_UPD_WR;
        present = side_q ? ask_map[price_q[AW-1:0]] : bid_map[price_q[AW-1:0]];
        if (bad_price || qty_q == '0) begin
          st_d = ST_BAD;
        end else begin
          case (kind_q)
            KIND_ADD: begin
              wdata = sum[QtyWidth] ? QtyMax : sum[QtyWidth-1:0];
            end
            KIND_MODIFY: begin
              if (!present) st_d = ST_MISSING;
              wdata = qty_q;
            end
            default: begin
              if (!present || rdata < qty_q) st_d = ST_EXCEEDS;
              wdata = rdata - qty_q;
            end
          endcase
          if (st_d == ST_OK) begin
            we_b = !side_q;  we_a = side_q;
            trk_set = 1'b1;
            trk_present = (wdata != '0);
          end
        end
      end
      S_UPD_WR: begin
        state_d = S_OUT;
      end
      S_DEPTH: begin
        maddr = scan_q;
        present = side_q ? ask_map[rd_q] : bid_map[rd_q];
        more = side_q ? |(ask_map >> rd_q >> 1)
                      : |(bid_map & ~({(MaxPrice + 1){1'b1}} << rd_q));
        if (present) begin
          lv_d = 1'b1;  lp_d = 7'(rd_q);  lq_d = rdata;
          any_d = 1'b1;
          cnt_d = cnt_q - 1'b1;
          lastf_d = (cnt_q == CW'(1)) || !more;
          state_d = S_OUT;
        end else if (rd_last_q) begin
          state_d = S_OUT;
          lv_d = 1'b0;  lp_d = '0;  lq_d = '0;  lastf_d = 1'b1;
        end
        if (!present || (cnt_q != CW'(1) && !rd_last_q)) begin
          rd_d = scan_q;
          rd_last_d = side_q ? (scan_q == MaxP) : (scan_q == '0);
          if (!rd_last_d) scan_d = side_q ? scan_q + 1'b1 : scan_q - 1'b1;
        end
        if (present && !any_q && lastf_d) begin
          lastf_d = 1'b1;
        end
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        maddr = rd_q;
        if (!out_stall_i) begin
          if (lv_q && !lastf_q) begin
            maddr = rd_q;
            state_d = S_DEPTH;
            if (!rd_last_q) begin
              rd_d = rd_q;
            end
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // When leaving S_OUT back into the walk, rd_q already points at the next
  // level to test and the memory is read again at that address.

  plob_mem #(.AddrWidth(AW), .Depth(MaxPrice + 1), .QtyWidth(QtyWidth)) u_bid (
    .clk_i, .we_i(we_b), .addr_i(maddr), .wdata_i(wdata), .rdata_o(rdata_b)
  );
  plob_mem #(.AddrWidth(AW), .Depth(MaxPrice + 1), .QtyWidth(QtyWidth)) u_ask (
    .clk_i, .we_i(we_a), .addr_i(maddr), .wdata_i(wdata), .rdata_o(rdata_a)
  );

  plob_top_track #(.MaxPrice(MaxPrice), .AddrWidth(AW)) u_track (
    .clk_i, .rst_ni, .set_i(trk_set), .side_i(mem_side), .addr_i(maddr),
    .present_i(trk_present), .bid_map_o(bid_map), .ask_map_o(ask_map),
    .bid_valid_o(bv), .bid_o(bb), .ask_valid_o(av), .ask_o(ba)
  );

  assign status_o = st_q;
  assign best_bid_valid_o = bv;
  assign best_ask_valid_o = av;
  assign best_bid_o = 7'(bb);
  assign best_ask_o = 7'(ba);
  assign spread_o = (bv && av) ? (8'(ba) - 8'(bb)) : '0;
  assign midpoint_twice_o = (bv && av) ? (8'(ba) + 8'(bb)) : '0;
  assign level_valid_o = lv_q;
  assign level_price_o = lp_q;
  assign level_quantity_o = lq_q;
  assign last_o = lastf_q;

`ifndef NO_ASSERTIONS
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> in_stall_o) else $error("input taken during clear");
  a_update_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !level_valid_o) |-> last_o) else $error("empty result not last");
  a_error_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD_WR && st_q != ST_OK) |-> ($stable(bid_map) && $stable(ask_map)))
    else $error("error changed book");
`endif

endmodule
